[hw/rtl/hcr_pkg.sv]
// ============================================================================
// hcr_pkg - types and constants for the Harris corner response unit
// ============================================================================
package hcr_pkg;

    localparam int WEIGHT_SHIFT = 20;
    localparam int WEIGHT_BITS  = 20;
    localparam int REG_W        = 60;
    localparam int RESP_W       = 36;
    localparam int GRAD_W       = 9;    // -255..255
    localparam int SQ_W         = 17;   // up to 65025 in magnitude
    localparam int TERM_W       = 38;   // signed product with 20-bit weight
    localparam int TERMS_W      = TERM_W - WEIGHT_SHIFT;
    localparam int C_W          = TERMS_W + 4;   // sum of nine terms
    localparam int S_W          = C_W + 1;
    localparam int P_W          = 2 * S_W + 2;

    localparam logic [1:0] REG_TOP    = 2'd0;
    localparam logic [1:0] REG_MIDDLE = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;

    localparam logic [REG_W-1:0] RST_TOP    = 60'd127247702767551507;
    localparam logic [REG_W-1:0] RST_MIDDLE = 60'd128527535534360735;
    localparam logic [REG_W-1:0] RST_BOTTOM = 60'd127247702767551507;

    localparam logic [10:0] K_TRACE = 11'd1311;

    typedef struct packed {
        logic [39:0] row_minus2;
        logic [39:0] row_minus1;
        logic [39:0] row_center;
        logic [39:0] row_plus1;
        logic [39:0] row_plus2;
        logic        last_point;
    } t_req;

    typedef struct packed {
        logic signed [RESP_W-1:0] response;
        logic                     last_result;
    } t_res;

endpackage

[hw/rtl/harris_corner_response_unit.sv]
// ============================================================================
// harris_corner_response_unit - Harris response of one 5x5 window
// One request per cycle, each giving one result strobe; the rate is set
// by the fully pipelined gradient, tensor and response datapath. The
// receiver cannot stall, so every result is shown for one cycle only.
// ============================================================================
module harris_corner_response_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  hcr_pkg::t_req        i_req,
    output logic                 o_strobe,
    output hcr_pkg::t_res        o_res,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [hcr_pkg::REG_W-1:0] i_cfg_data
);
    import hcr_pkg::*;

    logic [REG_W-1:0] r_wt, r_wm, r_wb;
    logic s_v, s_l;
    logic signed [C_W-1:0] s_c0, s_c1, s_c2;
    logic signed [S_W-1:0] r_s;
    logic signed [C_W-1:0] r_c0, r_c1, r_c2;
    logic signed [P_W-1:0] r_p01, r_p22;
    logic signed [S_W-1:0] r_s2, r_q;
    logic signed [P_W-1:0] r_sq, r_a;
    logic signed [P_W-1:0] n_resp;
    logic signed [RESP_W-1:0] r_resp;
    logic [3:0] r_v, r_l;
    logic signed [S_W+12:0] w_sk;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wt <= RST_TOP;
            r_wm <= RST_MIDDLE;
            r_wb <= RST_BOTTOM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TOP:    r_wt <= i_cfg_data;
                REG_MIDDLE: r_wm <= i_cfg_data;
                REG_BOTTOM: r_wb <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    hcr_window_sums u_sums (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start),
        .i_req     (i_req),
        .i_weights ({r_wb, r_wm, r_wt}),
        .o_valid   (s_v),
        .o_last    (s_l),
        .o_c0      (s_c0),
        .o_c1      (s_c1),
        .o_c2      (s_c2)
    );

    assign w_sk = r_s * $signed({1'b0, K_TRACE});

    always_comb begin
        n_resp = r_a - r_sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], s_v};
        end
        r_l <= {r_l[2:0], s_l};
        // stage 1
        r_s  <= S_W'(s_c0) + S_W'(s_c1);
        r_c0 <= s_c0;
        r_c1 <= s_c1;
        r_c2 <= s_c2;
        // stage 2
        r_p01 <= P_W'(r_c0) * P_W'(r_c1);
        r_p22 <= P_W'(r_c2) * P_W'(r_c2);
        r_q   <= S_W'(w_sk >>> 15);
        r_s2  <= r_s;
        // stage 3
        r_sq <= P_W'(r_s2) * P_W'(r_q);
        r_a  <= r_p01 - r_p22;
        // stage 4
        if (n_resp > P_W'(36'sh7FFFFFFFF)) begin
            r_resp <= 36'sh7FFFFFFFF;
        end else if (n_resp < -P_W'(37'sh800000000)) begin
            r_resp <= 36'sh800000000;
        end else begin
            r_resp <= RESP_W'(n_resp);
        end
    end

    assign o_strobe          = r_v[3];
    assign o_res.response    = r_resp;
    assign o_res.last_result = r_l[3];

endmodule

[hw/rtl/hcr_window_sums.sv]
// ============================================================================
// hcr_window_sums - Sobel gradients and weighted structure tensor sums
// Four stages: gradients, squares, weighting, summation.
// ============================================================================
module hcr_window_sums (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  hcr_pkg::t_req                     i_req,
    input  logic [3*hcr_pkg::REG_W-1:0]       i_weights,
    output logic                              o_valid,
    output logic                              o_last,
    output logic signed [hcr_pkg::C_W-1:0]    o_c0,
    output logic signed [hcr_pkg::C_W-1:0]    o_c1,
    output logic signed [hcr_pkg::C_W-1:0]    o_c2
);
    import hcr_pkg::*;

    logic [7:0] w_p [5][5];
    logic signed [GRAD_W-1:0] n_dx [9], n_dy [9];
    logic signed [GRAD_W-1:0] r_dx [9], r_dy [9];
    logic signed [SQ_W-1:0] r_xx [9], r_yy [9], r_xy [9];
    logic [WEIGHT_BITS-1:0] r_w1 [9], r_w2 [9];
    logic signed [TERMS_W-1:0] r_txx [9], r_tyy [9], r_txy [9];
    logic signed [C_W-1:0] n_c0, n_c1, n_c2;
    logic [3:0] r_v, r_l;
    logic signed [C_W-1:0] r_c0, r_c1, r_c2;
    logic [39:0] w_rows [5];

    assign w_rows[0] = i_req.row_minus2;
    assign w_rows[1] = i_req.row_minus1;
    assign w_rows[2] = i_req.row_center;
    assign w_rows[3] = i_req.row_plus1;
    assign w_rows[4] = i_req.row_plus2;

    always_comb begin
        for (int r = 0; r < 5; r++) begin
            for (int k = 0; k < 5; k++) begin
                w_p[r][k] = w_rows[r][8*k +: 8];
            end
        end
        for (int r = 1; r <= 3; r++) begin
            for (int k = 1; k <= 3; k++) begin
                logic signed [11:0] gx, gy;
                gx = $signed({4'd0, w_p[r-1][k+1]}) + $signed({3'd0, w_p[r][k+1], 1'b0})
                   + $signed({4'd0, w_p[r+1][k+1]}) - $signed({4'd0, w_p[r-1][k-1]})
                   - $signed({3'd0, w_p[r][k-1], 1'b0}) - $signed({4'd0, w_p[r+1][k-1]});
                gy = $signed({4'd0, w_p[r+1][k-1]}) + $signed({3'd0, w_p[r+1][k], 1'b0})
                   + $signed({4'd0, w_p[r+1][k+1]}) - $signed({4'd0, w_p[r-1][k-1]})
                   - $signed({3'd0, w_p[r-1][k], 1'b0}) - $signed({4'd0, w_p[r-1][k+1]});
                n_dx[(r-1)*3 + k-1] = gx[10:2];
                n_dy[(r-1)*3 + k-1] = gy[10:2];
            end
        end
    end

    always_comb begin
        n_c0 = '0;
        n_c1 = '0;
        n_c2 = '0;
        for (int j = 0; j < 9; j++) begin
            n_c0 = n_c0 + C_W'(r_txx[j]);
            n_c1 = n_c1 + C_W'(r_tyy[j]);
            n_c2 = n_c2 + C_W'(r_txy[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
        r_l <= {r_l[2:0], i_req.last_point};
        for (int j = 0; j < 9; j++) begin
            r_dx[j] <= n_dx[j];
            r_dy[j] <= n_dy[j];
            r_w1[j] <= i_weights[(j/3)*REG_W + (j%3)*WEIGHT_BITS +: WEIGHT_BITS];
            r_xx[j] <= SQ_W'(r_dx[j]) * SQ_W'(r_dx[j]);
            r_yy[j] <= SQ_W'(r_dy[j]) * SQ_W'(r_dy[j]);
            r_xy[j] <= SQ_W'(r_dx[j]) * SQ_W'(r_dy[j]);
            r_w2[j] <= r_w1[j];
            r_txx[j] <= TERMS_W'((TERM_W'(r_xx[j]) * TERM_W'($signed({1'b0, r_w2[j]})))
                                 >>> WEIGHT_SHIFT);
            r_tyy[j] <= TERMS_W'((TERM_W'(r_yy[j]) * TERM_W'($signed({1'b0, r_w2[j]})))
                                 >>> WEIGHT_SHIFT);
            r_txy[j] <= TERMS_W'((TERM_W'(r_xy[j]) * TERM_W'($signed({1'b0, r_w2[j]})))
                                 >>> WEIGHT_SHIFT);
        end
        r_c0 <= n_c0;
        r_c1 <= n_c1;
        r_c2 <= n_c2;
    end

    assign o_valid = r_v[3];
    assign o_last  = r_l[3];
    assign o_c0    = r_c0;
    assign o_c1    = r_c1;
    assign o_c2    = r_c2;

endmodule

[hw/rtl/hcr_checker.sv]
// ============================================================================
// hcr_checker - port level checks for the Harris response unit
// ============================================================================
module hcr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input hcr_pkg::t_req i_req,
    input logic          o_strobe,
    input hcr_pkg::t_res o_res
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##8 o_strobe) else $error("result missing");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##8 (o_res.last_result == $past(i_req.last_point, 8)))
        else $error("last flag mismatch");
    a_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_req.row_minus2 == i_req.row_center && i_req.row_center == i_req.row_plus2
         && i_req.row_minus1 == i_req.row_center && i_req.row_plus1 == i_req.row_center
         && i_req.row_center[7:0] == i_req.row_center[15:8]
         && i_req.row_center[15:8] == i_req.row_center[23:16]
         && i_req.row_center[23:16] == i_req.row_center[31:24]
         && i_req.row_center[31:24] == i_req.row_center[39:32])
        |-> ##8 (o_res.response == '0)) else $error("flat window nonzero");
endmodule

bind harris_corner_response_unit hcr_checker u_hcr_checker (.*);

[tb/tb_harris_corner_response_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_harris_corner_response_unit - self-checking bench for the Harris unit
// Directed windows and random bursts are checked against an in-bench
// Sobel/Gaussian predictor. The weight rows are stepped through reset,
// zero, full-scale and random settings, with saturation and the unused
// register index covered.
// ============================================================================
module tb_harris_corner_response_unit;
    import hcr_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_CYCLES = 12;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_req                 i_req = '0;
    logic                 o_strobe;
    t_res                 o_res;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_idx = '0;
    logic [REG_W-1:0]     i_cfg_data = '0;

    logic [REG_W-1:0]     weight_rows [3];
    t_res                 expected_responses [$];
    int                   error_count = 0;
    int                   cycle_count = 0;

    harris_corner_response_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_strobe   (o_strobe),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_res predict_response(input t_req req);
        logic [39:0] rows [5];
        longint      p [5][5];
        longint      c0, c1, c2, dx, dy, w, s, resp;
        t_res        res;
        rows[0] = req.row_minus2;
        rows[1] = req.row_minus1;
        rows[2] = req.row_center;
        rows[3] = req.row_plus1;
        rows[4] = req.row_plus2;
        for (int r = 0; r < 5; r++)
            for (int k = 0; k < 5; k++)
                p[r][k] = longint'(rows[r][8*k +: 8]);
        c0 = 0;
        c1 = 0;
        c2 = 0;
        for (int r = 1; r <= 3; r++) begin
            for (int k = 1; k <= 3; k++) begin
                w  = longint'(weight_rows[r-1][(k-1)*WEIGHT_BITS +: WEIGHT_BITS]);
                dx = (p[r-1][k+1] + 2*p[r][k+1] + p[r+1][k+1])
                   - (p[r-1][k-1] + 2*p[r][k-1] + p[r+1][k-1]);
                dy = (p[r+1][k-1] + 2*p[r+1][k] + p[r+1][k+1])
                   - (p[r-1][k-1] + 2*p[r-1][k] + p[r-1][k+1]);
                dx = dx >>> 2;
                dy = dy >>> 2;
                c0 += (dx*dx*w) >>> WEIGHT_SHIFT;
                c1 += (dy*dy*w) >>> WEIGHT_SHIFT;
                c2 += (dx*dy*w) >>> WEIGHT_SHIFT;
            end
        end
        s    = c0 + c1;
        resp = c0*c1 - c2*c2 - s*((s*1311) >>> 15);
        if (resp > 64'sd34359738367)
            resp = 64'sd34359738367;
        if (resp < -64'sd34359738368)
            resp = -64'sd34359738368;
        res.response    = resp[RESP_W-1:0];
        res.last_result = req.last_point;
        return res;
    endfunction

    // accepted requests feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            expected_responses.push_back(predict_response(i_req));
    end

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_strobe) begin
            if (expected_responses.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result %h", $realtime, o_res);
            end else begin
                exp_res = expected_responses.pop_front();
                if (o_res.response !== exp_res.response) begin
                    error_count++;
                    $display("%0t: response expected %0d actual %0d", $realtime,
                             exp_res.response, o_res.response);
                end
                if (o_res.last_result !== exp_res.last_result) begin
                    error_count++;
                    $display("%0t: last_result expected %b actual %b", $realtime,
                             exp_res.last_result, o_res.last_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("harris_corner_response_unit: mismatch");
            $finish;
        end
    end

    task automatic send_window(input t_req req);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (expected_responses.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_weights(input logic [1:0] idx, input logic [REG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx != REG_UNUSED)
            weight_rows[idx] = data;
    endtask

    task automatic set_all_weights(input logic [REG_W-1:0] data);
        write_weights(REG_TOP, data);
        write_weights(REG_MIDDLE, data);
        write_weights(REG_BOTTOM, data);
    endtask

    function automatic logic [39:0] rand_row();
        return {8'($urandom_range(255, 0)), $urandom()};
    endfunction

    function automatic t_req make_window(input int mode);
        t_req        req;
        logic [39:0] rows [5];
        int          lo, hi, base;
        lo   = $urandom_range(255, 0);
        hi   = $urandom_range(255, 0);
        base = $urandom_range(250, 0);
        for (int r = 0; r < 5; r++) begin
            case (mode)
                0: begin
                    rows[r] = rand_row();
                end
                1: begin
                    for (int k = 0; k < 5; k++)
                        rows[r][8*k +: 8] = 8'(base + $urandom_range(5, 0));
                end
                2: begin
                    for (int k = 0; k < 5; k++)
                        rows[r][8*k +: 8] = (k < 2 + (r % 2)) ? 8'(lo) : 8'(hi);
                end
                default: begin
                    for (int k = 0; k < 5; k++)
                        rows[r][8*k +: 8] = (r >= 2 && k >= 2) ? 8'(hi) : 8'(lo);
                end
            endcase
        end
        req.row_minus2 = rows[0];
        req.row_minus1 = rows[1];
        req.row_center = rows[2];
        req.row_plus1  = rows[3];
        req.row_plus2  = rows[4];
        req.last_point = ($urandom_range(7, 0) == 0);
        return req;
    endfunction

    function automatic t_req uniform_window(input logic [39:0] a, input logic [39:0] b,
                                            input logic last);
        t_req req;
        req.row_minus2 = a;
        req.row_minus1 = a;
        req.row_center = b;
        req.row_plus1  = b;
        req.row_plus2  = b;
        req.last_point = last;
        return req;
    endfunction

    task automatic test_directed_windows();
        t_req req;
        send_window(uniform_window('0, '0, 1'b0));
        send_window(uniform_window('1, '1, 1'b1));
        send_window(uniform_window('0, '1, 1'b0));
        send_window(uniform_window('1, '0, 1'b1));
        for (int i = 0; i < 5; i++) begin
            req = uniform_window(40'hFFFF_FF00_00 >> (8*i) | 40'h00_0000_0000,
                                 40'h0000_00FF_FF, i[0]);
            send_window(req);
        end
        send_window(uniform_window(40'hFF00_FF00_FF, 40'h00FF_00FF_00, 1'b0));
        send_window(uniform_window(40'hFFFF_FF00_00, 40'hFFFF_FF00_00, 1'b0));
        send_window(uniform_window(40'h0000_00FF_FF, 40'h0000_00FF_FF, 1'b1));
        // one-count steps: small gradients, some just below zero, exercise the signed shift
        send_window(uniform_window(40'h0000_0000_01, 40'h0000_0000_01, 1'b0));
        send_window(uniform_window(40'h0101_0101_01, 40'h0000_0000_00, 1'b0));
        send_window(uniform_window(40'h0000_0000_00, 40'h0101_0101_01, 1'b1));
        req.row_minus2 = 40'h0000_0000_00;
        req.row_minus1 = 40'h0000_FFFF_FF;
        req.row_center = 40'h0000_FFFF_FF;
        req.row_plus1  = 40'h0000_FFFF_FF;
        req.row_plus2  = 40'h0000_0000_00;
        req.last_point = 1'b1;
        send_window(req);
        wait_drained();
    endtask

    task automatic test_saturation();
        set_all_weights({REG_W{1'b1}});
        send_window(uniform_window('0, '1, 1'b0));
        send_window(make_window(3));
        send_window(make_window(2));
        wait_drained();
        write_weights(REG_MIDDLE, '0);
        send_window(uniform_window('1, '0, 1'b1));
        wait_drained();
    endtask

    task automatic test_unused_index();
        write_weights(REG_UNUSED, {REG_W{1'b1}});
        send_window(make_window(3));
        send_window(make_window(0));
        wait_drained();
    endtask

    task automatic random_windows(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(24, 1);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_window(make_window($urandom_range(3, 0)));
                sent++;
            end
            if ($urandom_range(3, 0) != 0)
                idle_cycles($urandom_range(9, 1));
        end
        wait_drained();
    endtask

    task automatic test_random_weights();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_all_weights('0);
                1: set_all_weights({REG_W{1'b1}});
                default: begin
                    write_weights(REG_TOP, REG_W'({$urandom(), $urandom()}));
                    write_weights(REG_MIDDLE, REG_W'({$urandom(), $urandom()}));
                    write_weights(REG_BOTTOM, REG_W'({$urandom(), $urandom()}));
                end
            endcase
            random_windows(150);
        end
    endtask

    task automatic test_reset_weights();
        write_weights(REG_TOP, RST_TOP);
        write_weights(REG_MIDDLE, RST_MIDDLE);
        write_weights(REG_BOTTOM, RST_BOTTOM);
        random_windows(330);
    endtask

    initial begin
        weight_rows[0] = RST_TOP;
        weight_rows[1] = RST_MIDDLE;
        weight_rows[2] = RST_BOTTOM;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_windows();
        random_windows(300);
        test_saturation();
        test_unused_index();
        test_random_weights();
        test_reset_weights();

        if (error_count == 0)
            $display("harris_corner_response_unit: match");
        else
            $display("harris_corner_response_unit: mismatch");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/hcr_pkg.sv
hw/rtl/hcr_window_sums.sv
hw/rtl/harris_corner_response_unit.sv
hw/rtl/hcr_checker.sv
tb/tb_harris_corner_response_unit.sv
